// ===== sv/sta_pkg.sv =====
// Package for the station temperature aggregator: sizes, byte codes, status codes and command types.
`default_nettype none
package sta_pkg;
	localparam int HASH_BUCKETS   = 1024;
	localparam int BUCKET_WAYS    = 2;
	localparam int MAX_NAME_BYTES = 64;
	localparam int ENTRIES        = HASH_BUCKETS * BUCKET_WAYS;
	localparam int NAME_WORDS     = (MAX_NAME_BYTES + 7) / 8;
	localparam int HASH_W  = $clog2(HASH_BUCKETS);
	localparam int WAY_W   = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
	localparam int ENTRY_W = $clog2(ENTRIES);
	localparam int LEN_W   = $clog2(MAX_NAME_BYTES + 1);
	localparam int NPOS_W  = $clog2(MAX_NAME_BYTES);
	localparam int WORD_W  = (NAME_WORDS > 1) ? $clog2(NAME_WORDS) : 1;
	localparam int NWADDR_W = $clog2(ENTRIES * NAME_WORDS);
	localparam int TEMP_W  = 15;
	localparam int MAG_W   = 14;
	localparam int SUM_W   = 48;
	localparam int CNT_W   = 32;

	localparam logic [MAG_W-1:0] TEMP_LIMIT = MAG_W'(9999);
	localparam logic [MAG_W-1:0] TEMP_SAT   = MAG_W'(10000);

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [2:0] ST_UPDATED  = 3'd0;
	localparam logic [2:0] ST_NEW      = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_LONG     = 3'd3;
	localparam logic [2:0] ST_RANGE    = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             clear_step;   // clear one valid bit after reset
		logic             take_byte;    // parse the input byte
		logic             start_way;    // load way counter and word counter
		logic             rd_entry;     // read metadata of the current way
		logic             rd_word;      // read the current name word
		logic             cmp_word;     // compare the word read last cycle
		logic             next_word;
		logic             next_way;
		logic             do_update;    // write updated statistics to current way
		logic             do_insert;    // write a new entry in current way
		logic             wr_word;      // write one name word of a new entry
		logic             finish;       // build the result and clear line state
		logic [2:0]       status;
	} sta_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic is_newline;
		logic overflow;
		logic out_of_range;
		logic way_valid;
		logic len_match;
		logic word_match;
		logic last_word;
		logic last_way;
	} sta_stat_t;
endpackage
`default_nettype wire

// ===== sv/sta_datapath.sv =====
// Datapath of the aggregator: line parser, hash, name buffer and entry memories.
`default_nettype none
module sta_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [7:0]           data_byte,
	input  wire sta_pkg::sta_cmd_t    cmd,
	output sta_pkg::sta_stat_t        stat,
	output logic [2:0]                res_status,
	output logic [sta_pkg::HASH_W-1:0] res_bucket,
	output logic                      res_way,
	output logic signed [14:0]        res_temp,
	output logic signed [14:0]        res_min,
	output logic signed [14:0]        res_max,
	output logic signed [47:0]        res_sum,
	output logic [31:0]               res_count,
	output logic                      res_bad
);
	import sta_pkg::*;

	logic [63:0]       name_words [NAME_WORDS];
	logic [LEN_W-1:0]  name_len_q;
	logic [HASH_W-1:0] hash_q;
	logic [MAG_W-1:0]  mag_q;
	logic              neg_q, dot_q, inval_q, bad_q, ovf_q;

	logic                valid_mem [ENTRIES];
	logic [ENTRY_W-1:0]  clr_q;
	logic [63:0]         word_mem [ENTRIES*NAME_WORDS];
	logic [LEN_W-1:0]    len_mem  [ENTRIES];
	logic signed [15:0]  min_mem  [ENTRIES];
	logic signed [15:0]  max_mem  [ENTRIES];
	logic signed [47:0]  sum_mem  [ENTRIES];
	logic [31:0]         cnt_mem  [ENTRIES];

	logic [WAY_W-1:0]  way_q;
	logic [WORD_W-1:0] word_q;
	logic [63:0]       word_rd_q;
	logic              valid_rd_q;
	logic [LEN_W-1:0]  len_rd_q;
	logic signed [15:0] min_rd_q, max_rd_q;
	logic signed [47:0] sum_rd_q;
	logic [31:0]       cnt_rd_q;
	logic              match_q;

	logic [ENTRY_W-1:0]  entry;
	logic [NWADDR_W-1:0] waddr;
	logic [63:0]         cur_word;
	logic signed [15:0]  t;
	logic signed [48:0]  sum_next;
	logic [HASH_W+5-1:0] h31;
	logic [7:0]          b;

	assign b = data_byte;
	if (BUCKET_WAYS > 1) begin : g_entry
		assign entry = ENTRY_W'({hash_q, way_q});
	end else begin : g_entry1
		assign entry = ENTRY_W'(hash_q);
	end
	assign waddr = NWADDR_W'(entry) * NWADDR_W'(NAME_WORDS) + NWADDR_W'(word_q);
	assign t = neg_q ? -$signed({2'b00, mag_q}) : $signed({2'b00, mag_q});

	// Name word taken from the line buffer; bytes at or beyond the length read as zero.
	always_comb begin
		cur_word = name_words[word_q];
		for (int i = 0; i < 8; i++) begin
			if (LEN_W'({word_q, 3'(i)}) >= name_len_q)
				cur_word[8*i +: 8] = 8'h00;
		end
	end

	// The byte enters the hash sign-extended, as a signed char would.
	assign h31 = (HASH_W+5)'({hash_q, 5'b0}) - (HASH_W+5)'(hash_q) + (HASH_W+5)'($signed(b));

	assign stat.clear_last   = (clr_q == ENTRY_W'(ENTRIES - 1));
	assign stat.is_newline   = (b == CH_NL);
	assign stat.overflow     = ovf_q;
	assign stat.out_of_range = (mag_q > TEMP_LIMIT);
	assign stat.way_valid    = valid_rd_q;
	assign stat.len_match    = (len_rd_q == name_len_q);
	assign stat.word_match   = match_q;
	assign stat.last_word    = (int'(word_q) == NAME_WORDS - 1);
	assign stat.last_way     = (int'(way_q) == BUCKET_WAYS - 1);

	always_ff @(posedge clk) begin
		if (cmd.take_byte && !inval_q && b != CH_SEMI && b != CH_NL
				&& name_len_q < LEN_W'(MAX_NAME_BYTES))
			name_words[name_len_q[NPOS_W-1:3]][{name_len_q[2:0], 3'b000} +: 8] <= b;
		if (cmd.clear_step)
			valid_mem[clr_q] <= 1'b0;
		else if (cmd.do_insert)
			valid_mem[entry] <= 1'b1;
		if (cmd.rd_entry) begin
			valid_rd_q <= valid_mem[entry];
			len_rd_q <= len_mem[entry];
			min_rd_q <= min_mem[entry];
			max_rd_q <= max_mem[entry];
			sum_rd_q <= sum_mem[entry];
			cnt_rd_q <= cnt_mem[entry];
		end
		if (cmd.rd_word)
			word_rd_q <= word_mem[waddr];
		if (cmd.wr_word)
			word_mem[waddr] <= cur_word;
		if (cmd.do_insert) begin
			len_mem[entry] <= name_len_q;
			min_mem[entry] <= t;
			max_mem[entry] <= t;
			sum_mem[entry] <= 48'(t);
			cnt_mem[entry] <= 32'd1;
		end
		if (cmd.do_update) begin
			min_mem[entry] <= (t < min_rd_q) ? t : min_rd_q;
			max_mem[entry] <= (t > max_rd_q) ? t : max_rd_q;
			sum_mem[entry] <= sum_next[48] != sum_next[47]
				? (sum_next[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}}) : sum_next[47:0];
			cnt_mem[entry] <= (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + 32'd1;
		end
	end

	assign sum_next = {sum_rd_q[47], sum_rd_q} + 49'(t);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_len_q <= '0; hash_q <= '0; mag_q <= '0;
			neg_q <= 1'b0; dot_q <= 1'b0; inval_q <= 1'b0; bad_q <= 1'b0; ovf_q <= 1'b0;
			clr_q <= '0; way_q <= '0; word_q <= '0; match_q <= 1'b0;
			res_status <= '0; res_bucket <= '0; res_way <= 1'b0; res_temp <= '0;
			res_min <= '0; res_max <= '0; res_sum <= '0; res_count <= '0; res_bad <= 1'b0;
		end else begin
			if (cmd.clear_step) clr_q <= clr_q + 1'b1;
			if (cmd.take_byte && b != CH_NL) begin
				if (!inval_q) begin
					if (b == CH_SEMI) inval_q <= 1'b1;
					else begin
						hash_q <= h31[HASH_W-1:0];
						if (name_len_q < LEN_W'(MAX_NAME_BYTES)) name_len_q <= name_len_q + 1'b1;
						else ovf_q <= 1'b1;
					end
				end else if (b == CH_SEMI) begin
				end else if (b == CH_DOT) dot_q <= 1'b1;
				else if (b == CH_MINUS) neg_q <= 1'b1;
				else if (b >= CH_ZERO && b <= CH_NINE) begin
					logic [17:0] nv;
					nv = dot_q ? 18'(mag_q) + 18'(b - CH_ZERO)
						: 18'(mag_q) * 18'd10 + 18'(b - CH_ZERO) * 18'd10;
					mag_q <= (nv > 18'(TEMP_LIMIT)) ? TEMP_SAT : nv[MAG_W-1:0];
				end else bad_q <= 1'b1;
			end
			if (cmd.start_way) begin way_q <= '0; word_q <= '0; end
			if (cmd.next_way) begin way_q <= way_q + 1'b1; word_q <= '0; end
			if (cmd.next_word) word_q <= word_q + 1'b1;
			if (cmd.cmp_word) match_q <= (word_rd_q == cur_word);
			if (cmd.finish) begin
				logic have;
				have = (cmd.status == ST_UPDATED) || (cmd.status == ST_NEW);
				res_status <= cmd.status;
				res_bucket <= hash_q;
				res_way    <= have ? way_q[0] : 1'b0;
				res_temp   <= (cmd.status == ST_RANGE) ? '0 : t[14:0];
				res_bad    <= bad_q;
				if (cmd.status == ST_NEW) begin
					res_min <= t[14:0]; res_max <= t[14:0]; res_sum <= 48'(t);
					res_count <= 32'd1;
				end else if (cmd.status == ST_UPDATED) begin
					res_min <= ((t < min_rd_q) ? t[14:0] : min_rd_q[14:0]);
					res_max <= ((t > max_rd_q) ? t[14:0] : max_rd_q[14:0]);
					res_sum <= sum_next[48] != sum_next[47]
						? (sum_next[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}}) : sum_next[47:0];
					res_count <= (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + 32'd1;
				end else begin
					res_min <= '0; res_max <= '0; res_sum <= '0; res_count <= '0;
				end
				name_len_q <= '0; hash_q <= '0; mag_q <= '0;
				neg_q <= 1'b0; dot_q <= 1'b0; inval_q <= 1'b0; bad_q <= 1'b0; ovf_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/sta_control.sv =====
// Controller of the aggregator: handshakes and the lookup, update and insert sequence.
`default_nettype none
module sta_control (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire sta_pkg::sta_stat_t stat,
	output sta_pkg::sta_cmd_t      cmd
);
	import sta_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0, S_META = 4'd1, S_CHKWAY = 4'd2, S_RDW = 4'd3,
		S_CMPW = 4'd4, S_CHKW = 4'd5, S_FREE = 4'd6, S_WRW = 4'd7, S_DONE = 4'd8,
		S_FRD = 4'd9, S_CLEAR = 4'd10;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic [2:0] status_q, status_d;
	logic       accept;

	// Input is held off outside S_IDLE; a newline also while a result still waits.
	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && stat.is_newline);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.status = status_q;
		state_d = state_q;
		status_d = status_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.take_byte = accept;
				if (accept && stat.is_newline) begin
					cmd.start_way = 1'b1;
					if (stat.overflow) begin status_d = ST_LONG; state_d = S_DONE; end
					else if (stat.out_of_range) begin status_d = ST_RANGE; state_d = S_DONE; end
					else state_d = S_META;
				end
			end
			S_META: begin cmd.rd_entry = 1'b1; state_d = S_CHKWAY; end
			S_CHKWAY: begin
				if (stat.way_valid && stat.len_match) state_d = S_RDW;
				else if (!stat.last_way) begin cmd.next_way = 1'b1; state_d = S_META; end
				else begin cmd.start_way = 1'b1; state_d = S_FRD; end
			end
			S_RDW: begin cmd.rd_word = 1'b1; state_d = S_CMPW; end
			S_CMPW: begin cmd.cmp_word = 1'b1; state_d = S_CHKW; end
			S_CHKW: begin
				if (!stat.word_match) begin
					if (!stat.last_way) begin cmd.next_way = 1'b1; state_d = S_META; end
					else begin cmd.start_way = 1'b1; state_d = S_FRD; end
				end else if (!stat.last_word) begin
					cmd.next_word = 1'b1; state_d = S_RDW;
				end else begin
					cmd.do_update = 1'b1; status_d = ST_UPDATED; state_d = S_DONE;
				end
			end
			S_FRD: begin cmd.rd_entry = 1'b1; state_d = S_FREE; end
			S_FREE: begin
				if (!stat.way_valid) begin
					cmd.do_insert = 1'b1; status_d = ST_NEW; state_d = S_WRW;
				end else if (!stat.last_way) begin
					cmd.next_way = 1'b1; state_d = S_FRD;
				end else begin status_d = ST_FULL; state_d = S_DONE; end
			end
			S_WRW: begin
				cmd.wr_word = 1'b1;
				if (stat.last_word) state_d = S_DONE;
				else cmd.next_word = 1'b1;
			end
			S_DONE: begin cmd.finish = 1'b1; state_d = S_IDLE; end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR; status_q <= ST_UPDATED; out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			status_q <= status_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ===== sv/station_temperature_aggregator_top.sv =====
// Top level of the station temperature aggregator.
// Ordinary bytes of a "name;temperature" line are taken one per cycle while
// the controller is idle. A newline starts a lookup in the bucket chosen by
// the name hash and holds the input off until its result is built. Each way
// probed is read (S_META) and its metadata checked (S_CHKWAY); a valid way
// whose stored length matches then reads, compares and checks each 64-bit
// name word in turn (S_RDW, S_CMPW, S_CHKW). A miss then rereads the ways
// (S_FRD, S_FREE) until a free one is found and writes NAME_WORDS name words
// (S_WRW). S_DONE registers the result; a dropped line goes there straight
// from its newline. A newline also waits while the previous result has not
// been taken. After reset a clearing pass (S_CLEAR) empties the valid bits,
// with the input stalled. The entry memories are single-ported. One result
// leaves per newline.
`default_nettype none
module station_temperature_aggregator_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         data_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              line_status,
	output logic [9:0]              bucket_index,
	output logic                    way_index,
	output logic signed [14:0]      line_temperature,
	output logic signed [14:0]      city_min,
	output logic signed [14:0]      city_max,
	output logic signed [47:0]      city_sum,
	output logic [31:0]             city_count,
	output logic                    bad_char_seen
);
	import sta_pkg::*;

	sta_cmd_t  cmd;
	sta_stat_t stat;

	sta_control u_ctl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
	);

	sta_datapath u_dp (
		.clk, .arst_n, .data_byte, .cmd, .stat,
		.res_status(line_status), .res_bucket(bucket_index), .res_way(way_index),
		.res_temp(line_temperature), .res_min(city_min), .res_max(city_max),
		.res_sum(city_sum), .res_count(city_count), .res_bad(bad_char_seen)
	);
endmodule
`default_nettype wire

// ===== tb/tb_station_temperature_aggregator_top.sv =====
// Self-checking testbench for the station temperature aggregator top level.
`default_nettype none
module tb_station_temperature_aggregator_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sta_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic [2:0]         status;
		logic [9:0]         bucket;
		logic               way;
		logic signed [14:0] temp;
		logic signed [14:0] tmin;
		logic signed [14:0] tmax;
		logic signed [47:0] tsum;
		logic [31:0]        cnt;
		logic               bad;
	} city_result_t;

	typedef struct {
		string      text;
		bit         known;
		logic [2:0] status;
		int         temp;
	} line_row_t;

	localparam int NROWS = 21;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam longint SUM_TOP = 64'sh7FFF_FFFF_FFFF;
	localparam longint SUM_BOTTOM = -SUM_TOP - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic out_stall = 1'b1;
	logic in_stall, out_valid, way_index, bad_char_seen;
	logic [2:0] line_status;
	logic [9:0] bucket_index;
	logic signed [14:0] line_temperature, city_min, city_max;
	logic signed [47:0] city_sum;
	logic [31:0] city_count;

	station_temperature_aggregator_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.line_status(line_status), .bucket_index(bucket_index), .way_index(way_index),
		.line_temperature(line_temperature), .city_min(city_min), .city_max(city_max),
		.city_sum(city_sum), .city_count(city_count), .bad_char_seen(bad_char_seen)
	);

	always #2 clk = ~clk;

	// Line parser state of the predictor.
	logic [7:0] cur_name[MAX_NAME_BYTES];
	int cur_len, cur_hash, cur_mag;
	bit cur_neg, cur_frac, cur_in_value, cur_bad, cur_long;

	// City table of the predictor.
	bit          city_valid[ENTRIES];
	logic [7:0]  city_name[ENTRIES][MAX_NAME_BYTES];
	int          city_len[ENTRIES];
	int          city_lo[ENTRIES];
	int          city_hi[ENTRIES];
	longint      city_total[ENTRIES];
	logic [31:0] city_readings[ENTRIES];

	city_result_t expected_results[$];
	logic [7:0] stream[$];
	line_row_t rows[NROWS];
	int lines_predicted = 0, results_taken = 0, bytes_taken = 0;
	int failures = 0, pause_at = -1;
	int status_seen[5];
	bit sending_done = 1'b0;

	task automatic clear_line_state();
		cur_len = 0;
		cur_hash = 0;
		cur_mag = 0;
		cur_neg = 0;
		cur_frac = 0;
		cur_in_value = 0;
		cur_bad = 0;
		cur_long = 0;
	endtask

	function automatic bit name_equal(int e);
		if (city_len[e] != cur_len)
			return 0;
		for (int i = 0; i < cur_len; i++)
			if (city_name[e][i] != cur_name[i])
				return 0;
		return 1;
	endfunction

	// Advances the line parser by one byte; a newline yields one expected result.
	task automatic aggregate_byte(input logic [7:0] b);
		city_result_t r;
		int sb, t, e, base;
		bit hit;
		longint s;
		r = '0;
		hit = 0;
		e = 0;
		if (b != CH_NL) begin
			if (!cur_in_value) begin
				if (b == CH_SEMI) begin
					cur_in_value = 1;
				end else begin
					sb = (b >= 128) ? int'(b) - 256 : int'(b);
					cur_hash = (cur_hash * 31 + sb) & (HASH_BUCKETS - 1);
					if (cur_len < MAX_NAME_BYTES) begin
						cur_name[cur_len] = b;
						cur_len++;
					end else begin
						cur_long = 1;
					end
				end
			end else if (b == CH_SEMI) begin
			end else if (b == CH_DOT) begin
				cur_frac = 1;
			end else if (b == CH_MINUS) begin
				cur_neg = 1;
			end else if (b >= CH_ZERO && b <= CH_NINE) begin
				if (cur_frac)
					cur_mag += int'(b - CH_ZERO);
				else
					cur_mag = cur_mag * 10 + int'(b - CH_ZERO) * 10;
				if (cur_mag > 9999)
					cur_mag = 10000;
			end else begin
				cur_bad = 1;
			end
			return;
		end
		t = cur_neg ? -cur_mag : cur_mag;
		base = cur_hash * BUCKET_WAYS;
		r.bucket = cur_hash[9:0];
		r.bad = cur_bad;
		r.temp = t[14:0];
		if (cur_long) begin
			r.status = ST_LONG;
		end else if (cur_mag > 9999) begin
			r.status = ST_RANGE;
			r.temp = '0;
		end else begin
			r.status = ST_FULL;
			for (int w = 0; w < BUCKET_WAYS && !hit; w++)
				if (city_valid[base + w] && name_equal(base + w)) begin
					hit = 1;
					e = base + w;
					r.way = w[0];
					r.status = ST_UPDATED;
				end
			if (hit) begin
				if (t < city_lo[e]) city_lo[e] = t;
				if (t > city_hi[e]) city_hi[e] = t;
				s = city_total[e] + t;
				if (s > SUM_TOP) s = SUM_TOP;
				if (s < SUM_BOTTOM) s = SUM_BOTTOM;
				city_total[e] = s;
				if (city_readings[e] != 32'hFFFF_FFFF)
					city_readings[e]++;
			end else begin
				for (int w = 0; w < BUCKET_WAYS && !hit; w++)
					if (!city_valid[base + w]) begin
						hit = 1;
						e = base + w;
						r.way = w[0];
						r.status = ST_NEW;
						city_valid[e] = 1;
						city_len[e] = cur_len;
						for (int i = 0; i < cur_len; i++)
							city_name[e][i] = cur_name[i];
						city_lo[e] = t;
						city_hi[e] = t;
						city_total[e] = t;
						city_readings[e] = 1;
					end
			end
			if (hit) begin
				r.tmin = city_lo[e][14:0];
				r.tmax = city_hi[e][14:0];
				r.tsum = city_total[e][47:0];
				r.cnt = city_readings[e];
			end
		end
		if (lines_predicted < NROWS && rows[lines_predicted].known) begin
			if (r.status != rows[lines_predicted].status
					|| r.temp != rows[lines_predicted].temp[14:0]) begin
				$display("%0t: line %0d expected status %0d temp %0d, predicted %0d %0d",
					$time, lines_predicted, rows[lines_predicted].status,
					rows[lines_predicted].temp, r.status, r.temp);
				failures++;
			end
		end
		lines_predicted++;
		expected_results.push_back(r);
		clear_line_state();
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			stream.push_back(s[i]);
	endtask

	task automatic push_bytes(input byte_q_t q);
		foreach (q[i])
			stream.push_back(q[i]);
	endtask

	function automatic byte_q_t random_name(int len);
		byte_q_t q;
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			do b = 8'($urandom_range(0, 255)); while (b == CH_NL || b == CH_SEMI);
			q.push_back(b);
		end
		return q;
	endfunction

	function automatic string random_reading();
		int mag;
		string s;
		case ($urandom_range(0, 19))
			0: mag = 9999;
			1: mag = 0;
			2: mag = 10000 + $urandom_range(0, 5000);
			default: mag = $urandom_range(0, 9999);
		endcase
		s = $sformatf("%0d.%0d", mag / 10, mag % 10);
		if ($urandom_range(0, 1))
			s = {"-", s};
		return s;
	endfunction

	task automatic build_stimulus();
		byte_q_t pool[$];
		byte_q_t q;
		string v;
		int k, n;
		rows = '{
			'{"Ab;12.3\n", 1, ST_NEW, 123},
			'{"Ab;-5.5\n", 0, ST_UPDATED, 0},
			'{"Ab;99.9\n", 0, ST_UPDATED, 0},
			'{"Aa;999.9\n", 1, ST_NEW, 9999},
			'{"BB;-999.9\n", 1, ST_NEW, -9999},
			'{"C#;0.0\n", 1, ST_FULL, 0},
			'{"Aa;-999.9\n", 0, ST_UPDATED, 0},
			'{"T;1000\n", 1, ST_RANGE, 0},
			'{"Q;12345\n", 1, ST_RANGE, 0},
			'{"abcdefghijabcdefghijabcdefghijabcdefghijabcdefghijabcdefghijabcd;2.5\n",
				1, ST_NEW, 25},
			'{"abcdefghijabcdefghijabcdefghijabcdefghijabcdefghijabcdefghijabcde;2.5\n",
				1, ST_LONG, 25},
			'{"noval\n", 1, ST_NEW, 0},
			'{"\n", 1, ST_NEW, 0},
			'{"B;1x2\n", 0, ST_NEW, 0},
			'{"C;;3\n", 1, ST_NEW, 30},
			'{"D;5-\n", 1, ST_NEW, -50},
			'{"E;1.99\n", 1, ST_NEW, 28},
			'{"\377\200z;-0.1\n", 1, ST_NEW, -1},
			'{"Ab;7\n", 0, ST_UPDATED, 0},
			'{"BB;-0.0\n", 0, ST_UPDATED, 0},
			'{"C#;\n", 1, ST_FULL, 0}
		};
		foreach (rows[i])
			push_text(rows[i].text);
		pause_at = stream.size();
		pool.push_back(random_name(MAX_NAME_BYTES));
		for (int i = 0; i < 40; i++)
			pool.push_back(random_name($urandom_range(1, 10)));
		while (stream.size() < 950) begin
			k = $urandom_range(0, 19);
			if (k < 14) begin
				// Well-formed line for a known city, so most lines reach the lookup.
				push_bytes(pool[$urandom_range(0, pool.size() - 1)]);
				push_text({";", random_reading(), "\n"});
			end else if (k < 16) begin
				q = {8'h41, 8'h61};
				if ($urandom_range(0, 1)) q = {8'h42, 8'h42};
				push_bytes(q);
				push_text({";", random_reading(), "\n"});
			end else if (k < 18) begin
				// Value with a stray byte in it.
				push_bytes(pool[$urandom_range(0, pool.size() - 1)]);
				v = random_reading();
				push_text({";", v.substr(0, 0)});
				stream.push_back(8'($urandom_range(0, 255)));
				push_text({v.substr(1, v.len() - 1), "\n"});
			end else begin
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++)
					stream.push_back(8'($urandom_range(0, 255)));
				stream.push_back(CH_NL);
			end
		end
	endtask

	// Sender.
	initial begin
		int g;
		foreach (status_seen[i])
			status_seen[i] = 0;
		clear_line_state();
		foreach (city_valid[i])
			city_valid[i] = 0;
		build_stimulus();
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int i = 0; i < stream.size(); i++) begin
			if (i == pause_at) begin
				in_valid <= 1'b0;
				wait (expected_results.size() == 0);
				@(negedge clk);
			end
			g = ((i / 150) % 3 == 2) ? 0 : $urandom_range(0, 8);
			if (g > 0) begin
				in_valid <= 1'b0;
				repeat (g) @(negedge clk);
			end
			in_valid <= 1'b1;
			data_byte <= stream[i];
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			@(negedge clk);
		end
		in_valid <= 1'b0;
		wait (expected_results.size() == 0);
		repeat (100) @(posedge clk);
		$display("Sent %0d bytes, %0d lines checked.", stream.size(), results_taken);
		$display("Statuses seen: updated %0d, new %0d, full %0d, long %0d, range %0d.",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (failures == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Receiver, with one long hold-off so the block backs up into its input.
	initial begin
		int g;
		bit held;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && results_taken >= 30) begin
				held = 1;
				out_stall <= 1'b1;
				repeat (300) @(negedge clk);
			end
			g = ((results_taken / 40) % 3 == 1) ? 0 : $urandom_range(0, 8);
			if (g > 0) begin
				out_stall <= 1'b1;
				repeat (g) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	city_result_t seen;
	assign seen = '{line_status, bucket_index, way_index, line_temperature,
		city_min, city_max, city_sum, city_count, bad_char_seen};

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			bytes_taken++;
			aggregate_byte(data_byte);
		end
		if (arst_n && out_valid && !out_stall) begin
			results_taken++;
			if (line_status <= ST_RANGE)
				status_seen[line_status]++;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, actual %p", $time, seen);
				failures++;
			end else begin
				if (seen !== expected_results[0]) begin
					$display("%0t: mismatch, expected %p, actual %p",
						$time, expected_results[0], seen);
					failures++;
				end
				void'(expected_results.pop_front());
			end
		end
	end

	// Ends the run if neither side moves for too long.
	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || !in_valid
					&& expected_results.size() == 0)
				idle = 0;
			else
				idle++;
			if (idle >= WATCHDOG_LIMIT) begin
				$display("Timeout with %0d results outstanding.", expected_results.size());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end
endmodule
`default_nettype wire

// ===== station_temperature_aggregator_top.f =====
sv/sta_pkg.sv
sv/sta_datapath.sv
sv/sta_control.sv
sv/station_temperature_aggregator_top.sv
tb/tb_station_temperature_aggregator_top.sv
